>>> hdl/dafifo_pkg.sv
// Shared constants, codes and helpers for the duplicate-rejecting address queue.
// Used by the core, the port checker and the testbench; no dependencies.
package dafifo_pkg;

  // Queue geometry.
  localparam int unsigned Depth = 64;
  localparam int unsigned IdxW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned AddrW = 64;

  // Operation codes carried on op_i.
  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpPop    = 2'd1;
  localparam logic [1:0] OpFind   = 2'd2;

  // Status codes returned on status_o.
  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  // Ring index advance with wrap from the last slot to slot zero.
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i);
    logic [IdxW-1:0] r;
    if (i == IdxW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = i + IdxW'(1);
    end
    return r;
  endfunction

endpackage

>>> hdl/dafifo_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the queue entries for the core.
module dafifo_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/dedup_address_fifo_core.sv
// Top level of the duplicate-rejecting address queue: sequencer, ring pointers
// and one shared 64-bit comparator. Depends on dafifo_pkg and dafifo_ram.
//
// Usage: a command word (op_i, address_i) is taken at a rising edge where
// start_i is high and busy_o is low. Each command gives exactly one result word
// on status_o and value_o, shown for one cycle while done_o is high; the
// receiver must take it in that cycle, it cannot hold results off.
// Insert and find walk the live entries oldest first with one comparator, one
// entry per cycle, reading the entry RAM through its registered read port;
// busy_o stays high for the walk, and a hit ends the walk early. Pop reads
// the head slot through the registered read port at the command edge, is busy
// in the pop state and returns the entry read as its result value.
// A pop of an empty queue, a find or insert on an empty queue, and the unused
// op code answer in the cycle after the command without raising busy_o.
// A new command may be issued in the cycle its predecessor's result is shown.
// Reset empties the queue at once (head, tail and occupancy cleared); entry
// contents are not cleared, as only live entries are ever compared or returned.
module dedup_address_fifo_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  op_i,
  input  logic [63:0] address_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] value_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StPop  = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [1:0]                   op_q, op_d;
  logic [dafifo_pkg::AddrW-1:0] addr_q, addr_d;
  logic [dafifo_pkg::IdxW-1:0]  head_q, head_d;
  logic [dafifo_pkg::IdxW-1:0]  tail_q, tail_d;
  logic [dafifo_pkg::CntW-1:0]  occ_q, occ_d;
  logic [dafifo_pkg::IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic [dafifo_pkg::CntW-1:0]  issued_q, issued_d;
  logic                         pend_q, pend_d;
  logic                         done_q, done_d;
  logic [1:0]                   status_q, status_d;
  logic [dafifo_pkg::AddrW-1:0] value_q, value_d;

  logic                         accept;
  logic                         hit;
  logic                         we;
  logic [dafifo_pkg::AddrW-1:0] wdata;
  logic [dafifo_pkg::IdxW-1:0]  raddr;
  logic [dafifo_pkg::AddrW-1:0] rdata;

  assign busy_o = (state_q != StIdle);
  assign accept = start_i && (state_q == StIdle);

  // The read port follows the walk while scanning and rests on the head otherwise.
  assign raddr = (state_q == StScan) ? rd_idx_q : head_q;

  // The one shared comparator.
  assign hit = pend_q && (rdata == addr_q);

  dafifo_ram #(
    .Width(dafifo_pkg::AddrW),
    .Depth(dafifo_pkg::Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(tail_q),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Sequencer: command decode, entry walk, pop and result formation.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    addr_d   = addr_q;
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    rd_idx_d = rd_idx_q;
    issued_d = issued_q;
    pend_d   = 1'b0;
    done_d   = 1'b0;
    status_d = status_q;
    value_d  = value_q;
    we       = 1'b0;
    wdata    = addr_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          op_d     = op_i;
          addr_d   = address_i;
          rd_idx_d = head_q;
          issued_d = '0;
          case (op_i)
            dafifo_pkg::OpInsert: begin
              if (occ_q == '0) begin
                // Nothing to compare against: append straight away.
                we       = 1'b1;
                wdata    = address_i;
                tail_d   = dafifo_pkg::next_idx(tail_q);
                occ_d    = occ_q + dafifo_pkg::CntW'(1);
                done_d   = 1'b1;
                status_d = dafifo_pkg::StOk;
                value_d  = '0;
              end else begin
                state_d = StScan;
              end
            end
            dafifo_pkg::OpFind: begin
              if (occ_q == '0) begin
                done_d   = 1'b1;
                status_d = dafifo_pkg::StMiss;
                value_d  = '0;
              end else begin
                state_d = StScan;
              end
            end
            dafifo_pkg::OpPop: begin
              if (occ_q == '0) begin
                done_d   = 1'b1;
                status_d = dafifo_pkg::StMiss;
                value_d  = '0;
              end else begin
                state_d = StPop;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = dafifo_pkg::StMiss;
              value_d  = '0;
            end
          endcase
        end
      end

      StScan: begin
        // Issue the next live entry while comparing the one read last cycle.
        if (issued_q != occ_q) begin
          rd_idx_d = dafifo_pkg::next_idx(rd_idx_q);
          issued_d = issued_q + dafifo_pkg::CntW'(1);
          pend_d   = 1'b1;
        end
        if (pend_q && (hit || (issued_q == occ_q))) begin
          state_d = StIdle;
          pend_d  = 1'b0;
          done_d  = 1'b1;
          value_d = '0;
          if (op_q == dafifo_pkg::OpFind) begin
            status_d = hit ? dafifo_pkg::StOk : dafifo_pkg::StMiss;
          end else if (hit) begin
            status_d = dafifo_pkg::StMiss;
          end else if (occ_q == dafifo_pkg::CntW'(dafifo_pkg::Depth)) begin
            status_d = dafifo_pkg::StFull;
          end else begin
            we       = 1'b1;
            tail_d   = dafifo_pkg::next_idx(tail_q);
            occ_d    = occ_q + dafifo_pkg::CntW'(1);
            status_d = dafifo_pkg::StOk;
          end
        end
      end

      StPop: begin
        // Head entry was read at the command edge.
        state_d  = StIdle;
        head_d   = dafifo_pkg::next_idx(head_q);
        occ_d    = occ_q - dafifo_pkg::CntW'(1);
        done_d   = 1'b1;
        status_d = dafifo_pkg::StOk;
        value_d  = rdata;
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      head_q   <= '0;
      tail_q   <= '0;
      occ_q    <= '0;
      issued_q <= '0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      occ_q    <= occ_d;
      issued_q <= issued_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    addr_q   <= addr_d;
    rd_idx_q <= rd_idx_d;
    status_q <= status_d;
    value_q  <= value_d;
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign value_o  = value_q;

endmodule

>>> hdl/dafifo_checker.sv
// Port-level checker for the duplicate-rejecting address queue, bound to the core.
// Depends on dafifo_pkg for the status codes.
module dafifo_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [63:0] value_o
);

  // An accepted word either starts a busy phase or answers at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted word neither busy nor answered");

  // A result is shown only once the sequencer is back to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while busy");

  // Leaving the busy phase always delivers a result.
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy phase ended without a result");

  // A result with a status other than ok carries a zero value.
  a_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != dafifo_pkg::StOk)) |-> (value_o == '0))
    else $error("value nonzero on a failed operation");

  // Status is always one of the defined codes.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((status_o == dafifo_pkg::StOk) || (status_o == dafifo_pkg::StMiss) ||
                (status_o == dafifo_pkg::StFull)))
    else $error("undefined status code");

endmodule

bind dedup_address_fifo_core dafifo_checker u_dafifo_checker (.*);

>>> sim/tb.sv
// Self-checking testbench for dedup_address_fifo_core: directed table, then random commands.
// Depends on dafifo_pkg for the geometry, the op codes and the status codes.
module tb;

  // Op code three has no function and must come back as a miss.
  localparam logic [1:0] OpUnused  = 2'd3;
  localparam int         RandItems = 310;
  localparam int         PoolSize  = 16;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] value;
  } result_word_t;

  // One directed row, repeated count times with the address stepping up by one.
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr;
    logic [7:0]  count;
    logic        fixed;
    logic [1:0]  st;
    logic [63:0] val;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  op_i;
  logic [63:0] address_i;
  logic        done_o;
  logic [1:0]  status_o;
  logic [63:0] value_o;

  // Shadow copy of the ring, stepped on every accepted command; it predicts the result words that no fixed row gives.
  logic [63:0]                 ring_mem [dafifo_pkg::Depth];
  logic [dafifo_pkg::IdxW-1:0] ring_head;
  logic [dafifo_pkg::IdxW-1:0] ring_tail;
  int unsigned                 ring_count;

  result_word_t pending_results [$];
  stim_row_t    dir_rows [$];
  int           taken_words;
  int           mismatches;
  int           idle_pct;
  logic         fixed_valid;
  result_word_t fixed_word;
  logic [63:0]  addr_pool [PoolSize];

  dedup_address_fifo_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .busy_o    (busy_o),
    .op_i      (op_i),
    .address_i (address_i),
    .done_o    (done_o),
    .status_o  (status_o),
    .value_o   (value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: a correct run ends long before this.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Apply one command to the shadow ring and return the word the queue should answer.
  task automatic queue_model_step(input logic [1:0] op, input logic [63:0] addr,
                                  output result_word_t res);
    logic                        hit;
    int unsigned                 k;
    logic [dafifo_pkg::IdxW-1:0] idx;
    hit = 1'b0;
    idx = ring_head;
    res.status = dafifo_pkg::StMiss;
    res.value  = '0;
    for (k = 0; k < ring_count; k++) begin
      if (ring_mem[idx] == addr) hit = 1'b1;
      idx = dafifo_pkg::next_idx(idx);
    end
    case (op)
      dafifo_pkg::OpInsert: begin
        // The duplicate check wins over the full check.
        if (hit) begin
          res.status = dafifo_pkg::StMiss;
        end else if (ring_count >= dafifo_pkg::Depth) begin
          res.status = dafifo_pkg::StFull;
        end else begin
          ring_mem[ring_tail] = addr;
          ring_tail = dafifo_pkg::next_idx(ring_tail);
          ring_count++;
          res.status = dafifo_pkg::StOk;
        end
      end
      dafifo_pkg::OpPop: begin
        if (ring_count != 0) begin
          res.value = ring_mem[ring_head];
          ring_head = dafifo_pkg::next_idx(ring_head);
          ring_count--;
          res.status = dafifo_pkg::StOk;
        end
      end
      dafifo_pkg::OpFind: begin
        res.status = hit ? dafifo_pkg::StOk : dafifo_pkg::StMiss;
      end
      default: begin
      end
    endcase
  endtask

  // Check result words against the oldest expectation, then record an accepted command.
  always @(posedge clk_i) begin
    result_word_t want;
    result_word_t model;
    if (done_o) begin
      if (pending_results.size() == 0) begin
        $error("result word with no command outstanding: status %0d value %h",
               status_o, value_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (value_o !== want.value) begin
          $error("value mismatch: expected %h, got %h", want.value, value_o);
          mismatches++;
        end
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      queue_model_step(op_i, address_i, model);
      pending_results.push_back(fixed_valid ? fixed_word : model);
      taken_words++;
    end
  end

  // Present one command word and hold it until the queue takes it.
  task automatic send_cmd(input logic [1:0] op, input logic [63:0] addr);
    int target;
    target = taken_words + 1;
    start_i   <= 1'b1;
    op_i      <= op;
    address_i <= addr;
    do @(negedge clk_i); while (taken_words != target);
  endtask

  // Random gap on the sender side, mostly short, now and then long enough to span a search.
  task automatic maybe_idle();
    int n;
    if ($urandom_range(99) < idle_pct) begin
      n = ($urandom_range(7) == 0) ? $urandom_range(8, 70) : $urandom_range(1, 3);
      start_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // Stop sending until every expected result word has come back.
  task automatic wait_drained();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  initial begin
    int          r;
    int          i;
    int          n;
    int          pick;
    logic        filling;
    logic [1:0]  op;
    logic [63:0] addr;
    stim_row_t   row;

    rst_ni      = 1'b0;
    start_i     = 1'b0;
    op_i        = dafifo_pkg::OpInsert;
    address_i   = '0;
    taken_words = 0;
    mismatches  = 0;
    idle_pct    = 34;
    fixed_valid = 1'b0;
    fixed_word  = '0;
    ring_head   = '0;
    ring_tail   = '0;
    ring_count  = 0;

    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (i = 2; i < PoolSize; i++) addr_pool[4'(i)] = {$urandom, $urandom};

    // Empty queue: pop, find and the unused code all miss.
    dir_rows.push_back('{dafifo_pkg::OpPop,    64'h0, 8'd1, 1'b1, dafifo_pkg::StMiss, 64'h0});
    dir_rows.push_back('{dafifo_pkg::OpFind,   64'h0, 8'd1, 1'b1, dafifo_pkg::StMiss, 64'h0});
    dir_rows.push_back('{OpUnused,             64'h0, 8'd1, 1'b1, dafifo_pkg::StMiss, 64'h0});
    // Address extremes, a duplicate insert, hits and a miss.
    dir_rows.push_back('{dafifo_pkg::OpInsert, 64'h0, 8'd1, 1'b1, dafifo_pkg::StOk,   64'h0});
    dir_rows.push_back('{dafifo_pkg::OpInsert, 64'h0, 8'd1, 1'b1, dafifo_pkg::StMiss, 64'h0});
    dir_rows.push_back('{dafifo_pkg::OpInsert, '1,    8'd1, 1'b1, dafifo_pkg::StOk,   64'h0});
    dir_rows.push_back('{dafifo_pkg::OpFind,   '1,    8'd1, 1'b1, dafifo_pkg::StOk,   64'h0});
    dir_rows.push_back('{dafifo_pkg::OpFind,   64'h5555_5555_5555_5555, 8'd1, 1'b1,
                         dafifo_pkg::StMiss, 64'h0});
    dir_rows.push_back('{dafifo_pkg::OpFind,   64'h0, 8'd1, 1'b1, dafifo_pkg::StOk,   64'h0});
    // A popped zero comes back with an ok status, unlike an empty pop.
    dir_rows.push_back('{dafifo_pkg::OpPop,    64'h0, 8'd1, 1'b1, dafifo_pkg::StOk,   64'h0});
    dir_rows.push_back('{dafifo_pkg::OpPop,    '1,    8'd1, 1'b1, dafifo_pkg::StOk,   '1});
    dir_rows.push_back('{dafifo_pkg::OpPop,    '1,    8'd1, 1'b1, dafifo_pkg::StMiss, 64'h0});
    dir_rows.push_back('{OpUnused,             '1,    8'd1, 1'b1, dafifo_pkg::StMiss, 64'h0});
    // Fill the ring from a nonzero slot so the tail wraps, then overflow it.
    dir_rows.push_back('{dafifo_pkg::OpInsert, 64'hA000_0000_0000_0000, 8'd64, 1'b1,
                         dafifo_pkg::StOk, 64'h0});
    dir_rows.push_back('{dafifo_pkg::OpInsert, 64'hFFFF_FFFF_FFFF_FFFE, 8'd1, 1'b1,
                         dafifo_pkg::StFull, 64'h0});
    // Duplicates into a full ring still report a duplicate, not full.
    dir_rows.push_back('{dafifo_pkg::OpInsert, 64'hA000_0000_0000_003F, 8'd1, 1'b1,
                         dafifo_pkg::StMiss, 64'h0});
    dir_rows.push_back('{dafifo_pkg::OpInsert, 64'hA000_0000_0000_0000, 8'd1, 1'b1,
                         dafifo_pkg::StMiss, 64'h0});
    dir_rows.push_back('{dafifo_pkg::OpFind,   64'hA000_0000_0000_001F, 8'd1, 1'b1,
                         dafifo_pkg::StOk, 64'h0});
    dir_rows.push_back('{OpUnused,             64'hA000_0000_0000_0001, 8'd1, 1'b1,
                         dafifo_pkg::StMiss, 64'h0});
    // From here on the predictor supplies the expected words.
    dir_rows.push_back('{dafifo_pkg::OpPop,    64'h0, 8'd3, 1'b0, dafifo_pkg::StOk, 64'h0});
    dir_rows.push_back('{dafifo_pkg::OpInsert, 64'hFFFF_FFFF_FFFF_FFFE, 8'd3, 1'b0,
                         dafifo_pkg::StOk, 64'h0});
    dir_rows.push_back('{dafifo_pkg::OpInsert, 64'h1234, 8'd1, 1'b0, dafifo_pkg::StOk, 64'h0});
    dir_rows.push_back('{dafifo_pkg::OpFind,   64'h0, 8'd1, 1'b0, dafifo_pkg::StOk, 64'h0});

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part.
    for (r = 0; r < dir_rows.size(); r++) begin
      row = dir_rows[r];
      for (i = 0; i < row.count; i++) begin
        fixed_valid = row.fixed;
        fixed_word  = '{row.st, row.val};
        send_cmd(row.op, row.addr + 64'(i));
        maybe_idle();
      end
    end
    fixed_valid = 1'b0;
    wait_drained();

    // Random part: alternate between filling the ring to overflow and draining it.
    filling = 1'b0;
    for (n = 0; n < RandItems; n++) begin
      if (n == RandItems / 3) begin
        wait_drained();
        idle_pct = 76;
      end else if (n == 2 * RandItems / 3) begin
        wait_drained();
        idle_pct = 0;
      end
      if (filling && ring_count >= dafifo_pkg::Depth && $urandom_range(7) == 0) begin
        filling = 1'b0;
      end else if (!filling && ring_count == 0 && $urandom_range(3) == 0) begin
        filling = 1'b1;
      end
      pick = $urandom_range(99);
      if (filling) begin
        op = (pick < 72) ? dafifo_pkg::OpInsert : (pick < 80) ? dafifo_pkg::OpPop :
             (pick < 95) ? dafifo_pkg::OpFind : OpUnused;
      end else begin
        op = (pick < 20) ? dafifo_pkg::OpInsert : (pick < 75) ? dafifo_pkg::OpPop :
             (pick < 95) ? dafifo_pkg::OpFind : OpUnused;
      end
      // Pool addresses produce duplicates and hits; fresh ones cover every bit.
      if ($urandom_range(99) < ((op == dafifo_pkg::OpInsert) ? 30 : 60)) begin
        addr = addr_pool[4'($urandom_range(PoolSize - 1))];
      end else begin
        addr = {$urandom, $urandom};
      end
      send_cmd(op, addr);
      maybe_idle();
    end

    // Let every result come back, then watch a while for stray words.
    wait_drained();
    repeat (dafifo_pkg::Depth + 8) @(negedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
